// ===== src/ir_beacon_frame_transmitter_defines.svh =====
// Assertion macros shared by the IR beacon frame transmitter RTL.
`ifndef IR_BEACON_FRAME_TRANSMITTER_DEFINES_SVH
`define IR_BEACON_FRAME_TRANSMITTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define IBFT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ibft: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define IBFT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ibft: next-cycle check failed");

`endif

// ===== src/ibft_pkg.sv =====
// Package: constants and types of the IR beacon frame transmitter.
`default_nettype none
package ibft_pkg;

    localparam int SYMBOL_TICKS  = 15;
    localparam int FRAME_REPEATS = 3;

    localparam int TICK_W  = $clog2(SYMBOL_TICKS + 1);
    localparam int FRAME_W = $clog2(FRAME_REPEATS + 1);
    localparam int IDX_W   = 6;
    localparam int PAIR_W  = 2;
    localparam int NIB_W   = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [IDX_W-1:0]  FIRST_INDEX = IDX_W'(51);
    localparam logic [PAIR_W-1:0] PAIR_STARTS = PAIR_W'(3);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_NUMBER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_SPEED  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_STATUS = CFG_IDX_W'(2);

    typedef struct packed {
        logic [NIB_W-1:0] number;
        logic [NIB_W-1:0] speed;
        logic [NIB_W-1:0] status;
    } t_fields;

    localparam t_fields FIELDS_RESET = '{number: 4'd0, speed: 4'd4, status: 4'd8};

    typedef struct packed {
        logic carrier_on;
        logic burst_active;
        logic frame_reloaded;
    } t_result;

endpackage
`default_nettype wire

// ===== src/ibft_cfg.sv =====
// Configuration registers: robot number, speed and status.
`default_nettype none
module ibft_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [ibft_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [ibft_pkg::NIB_W-1:0]     i_cfg_wr_data,
    output ibft_pkg::t_fields                   o_cfg
);
    import ibft_pkg::*;

    t_fields r_cfg;
    t_fields n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_ROBOT_NUMBER: n_cfg.number = i_cfg_wr_data;
                CFG_ROBOT_SPEED:  n_cfg.speed  = i_cfg_wr_data;
                CFG_ROBOT_STATUS: n_cfg.status = i_cfg_wr_data;
                default:          n_cfg = r_cfg; // unused index: drop
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= FIELDS_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== src/ibft_seq.sv =====
// Frame sequencer: tick, symbol, pair and frame counters plus symbol lookup.
`default_nettype none
`include "ir_beacon_frame_transmitter_defines.svh"
module ibft_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire ibft_pkg::t_fields i_cfg,
    output ibft_pkg::t_result      o_result
);
    import ibft_pkg::*;

    logic [TICK_W-1:0]  r_tick_count,  n_tick_count;
    logic [IDX_W-1:0]   r_symbol_index, n_symbol_index;
    logic [PAIR_W-1:0]  r_pair_count,  n_pair_count;
    logic [FRAME_W-1:0] r_frame_count, n_frame_count;
    logic               r_active,      n_active;
    logic               r_symbol,      n_symbol;
    t_fields            r_fields,      n_fields;
    logic               n_reloaded;
    logic               at_frame_start;

    // Symbol value at a given index; index FIRST_INDEX opens the frame, 0 closes it.
    function automatic logic symbol_at(input logic [IDX_W-1:0] idx, input t_fields f);
        logic [NIB_W-1:0] chk;
        logic [15:0]      word;
        logic [IDX_W-1:0] k;
        logic [11:0]      prod;
        logic [4:0]       grp;
        logic [IDX_W-1:0] pos;
        logic             res;
        chk  = 4'd0 - f.number - f.speed - f.status;
        word = {f.number, f.speed, f.status, chk};
        k    = idx - IDX_W'(2);
        // k / 3 as a reciprocal multiply, exact for k below 64
        prod = 12'(k) * 12'd43;
        grp  = prod[11:7];
        pos  = k - IDX_W'({grp, 1'b0}) - IDX_W'(grp);
        priority if (idx >= FIRST_INDEX)               res = 1'b1;
        else if (idx == FIRST_INDEX - IDX_W'(1))       res = 1'b0;
        else if (idx == IDX_W'(1))                     res = 1'b1;
        else if (idx == IDX_W'(0))                     res = 1'b0;
        else if (pos == IDX_W'(2))                     res = 1'b1;
        else if (pos == IDX_W'(0))                     res = 1'b0;
        else                                           res = word[grp[3:0]];
        return res;
    endfunction

    always_comb begin
        logic [TICK_W-1:0] tick_dec;
        n_tick_count   = r_tick_count;
        n_symbol_index = r_symbol_index;
        n_pair_count   = r_pair_count;
        n_frame_count  = r_frame_count;
        n_active       = r_active;
        n_symbol       = r_symbol;
        n_fields       = r_fields;
        n_reloaded     = 1'b0;
        tick_dec       = (r_tick_count != '0) ? r_tick_count - TICK_W'(1) : r_tick_count;
        if (i_advance) begin
            n_tick_count = tick_dec;
            if (tick_dec == '0) begin
                if (r_symbol_index != '0) begin
                    n_symbol_index = r_symbol_index - IDX_W'(1);
                end else begin
                    // trailing pair: resend 1,0
                    n_symbol_index = IDX_W'(1);
                    n_pair_count   = r_pair_count + PAIR_W'(1);
                end
                if (n_pair_count == PAIR_STARTS) begin
                    n_symbol_index = FIRST_INDEX;
                    n_pair_count   = '0;
                    if (r_active) begin
                        n_frame_count = r_frame_count + FRAME_W'(1);
                    end else if (r_frame_count != '0) begin
                        n_frame_count = r_frame_count - FRAME_W'(1);
                    end
                    if (n_frame_count == FRAME_W'(FRAME_REPEATS)) n_active = 1'b0;
                    if (n_frame_count == '0) begin
                        n_fields   = i_cfg;
                        n_active   = 1'b1;
                        n_reloaded = 1'b1;
                    end
                end
                n_symbol     = symbol_at(n_symbol_index, n_fields);
                n_tick_count = TICK_W'(SYMBOL_TICKS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count   <= TICK_W'(SYMBOL_TICKS);
            r_symbol_index <= FIRST_INDEX;
            r_pair_count   <= '0;
            r_frame_count  <= '0;
            r_active       <= 1'b1;
            r_symbol       <= 1'b1;
            r_fields       <= FIELDS_RESET;
        end else begin
            r_tick_count   <= n_tick_count;
            r_symbol_index <= n_symbol_index;
            r_pair_count   <= n_pair_count;
            r_frame_count  <= n_frame_count;
            r_active       <= n_active;
            r_symbol       <= n_symbol;
            r_fields       <= n_fields;
        end
    end

    assign o_result.carrier_on     = r_symbol & r_active;
    assign o_result.burst_active   = r_active;
    assign o_result.frame_reloaded = n_reloaded;

    assign at_frame_start = r_active && (r_frame_count == '0) && (r_symbol_index == FIRST_INDEX);

    `IBFT_ASSERT_IMP(a_tick_nonzero, i_clk, i_rst_n, 1'b1, r_tick_count != '0)
    `IBFT_ASSERT_IMP(a_pair_below_limit, i_clk, i_rst_n, 1'b1, r_pair_count < PAIR_STARTS)
    `IBFT_ASSERT_NXT(a_reload_starts_burst, i_clk, i_rst_n, n_reloaded, at_frame_start)

endmodule
`default_nettype wire

// ===== src/ibft_out_buf.sv =====
// Result register with skid entry between the sequencer and the output channel.
`default_nettype none
`include "ir_beacon_frame_transmitter_defines.svh"
module ibft_out_buf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire ibft_pkg::t_result i_data,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output ibft_pkg::t_result      o_data
);
    import ibft_pkg::*;

    logic    r_out_valid,  n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out,        n_out;
    t_result r_skid,       n_skid;
    logic    take;

    assign take = r_out_valid & ~i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            // no push while the skid entry is occupied
            if (take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (!r_out_valid || take) begin
            n_out_valid = i_push;
            if (i_push) n_out = i_data;
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `IBFT_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `IBFT_ASSERT_NXT(a_skid_holds, i_clk, i_rst_n, r_skid_valid && i_stall, r_skid_valid && $stable(r_skid))
    `IBFT_ASSERT_NXT(a_push_lands, i_clk, i_rst_n, i_push && !r_skid_valid, r_out_valid)

endmodule
`default_nettype wire

// ===== src/ir_beacon_frame_transmitter.sv =====
// Top level of the IR beacon frame transmitter.
//
//  Channel   Direction  Handshake                    Payload
//  ------    ---------  ---------------------------  --------------------------------
//  in        sink       i_in_valid / o_in_stall      i_tick_enable
//  out       source     o_out_valid / i_out_stall    o_carrier_on, o_burst_active,
//                                                    o_frame_reloaded
//  cfg       sink       i_cfg_wr_en                  i_cfg_addr, i_cfg_wr_data
//
// One transaction is taken every clock cycle unless the input stalls; its result
// lands in the result register, or in the skid entry behind a stalled output.
// The path from the sequencer state into that register is combinational.
// Reset is synchronous and active low; state comes up ready for the first frame.
// A stalled output keeps its result; a skid entry absorbs one more transaction,
// and the input stalls only while that entry is occupied.
`default_nettype none
module ir_beacon_frame_transmitter (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_tick_enable,
    // output channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_carrier_on,
    output logic                                o_burst_active,
    output logic                                o_frame_reloaded,
    // configuration port
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [ibft_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [ibft_pkg::NIB_W-1:0]     i_cfg_wr_data
);
    import ibft_pkg::*;

    t_fields cfg;
    t_result seq_result;
    t_result out_data;
    logic    buf_full;
    logic    in_accept;

    // accept a transaction whenever the skid entry is free
    assign o_in_stall = buf_full;
    assign in_accept  = i_in_valid & ~buf_full;

    // register file; values are only picked up at the next relatch
    ibft_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cfg         (cfg)
    );

    // advance the counters only on an accepted transaction with the tick set
    ibft_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (in_accept & i_tick_enable),
        .i_cfg     (cfg),
        .o_result  (seq_result)
    );

    // every accepted transaction yields exactly one result
    ibft_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (seq_result),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_data)
    );

    assign o_carrier_on     = out_data.carrier_on;
    assign o_burst_active   = out_data.burst_active;
    assign o_frame_reloaded = out_data.frame_reloaded;

endmodule
`default_nettype wire

// ===== tb/sv/tb_ir_beacon_frame_transmitter.sv =====
// Self-checking testbench for the IR beacon frame transmitter: random ticks, stalls and writes.
`default_nettype none
module tb_ir_beacon_frame_transmitter;
    import ibft_pkg::*;

    // Index past the register list: the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

    // Three random phases of about 310 transactions each, even with the
    // heavy stall and idle mixes,
    // stay well below this bound.
    localparam int CYCLE_LIMIT   = 20_000;
    localparam int PHASE_TICKS   = 235;
    localparam int HOLD_OFF_LONG = 60;

    // Mirrors the sequencer tick by tick and queues the outputs it should
    // show; results are taken off the front in order of arrival.
    class carrier_scoreboard;
        t_fields            regs;
        t_fields            latched;
        logic [TICK_W-1:0]  tick_cnt;
        logic [IDX_W-1:0]   sym_idx;
        logic [PAIR_W-1:0]  pair_cnt;
        logic [FRAME_W-1:0] frame_cnt;
        logic               active;
        logic               cur_sym;
        t_result            expected_outputs[$];
        int                 errors;
        int                 checked;
        int                 relatches;
        int                 held;
        int                 ticks;

        function new();
            regs      = FIELDS_RESET;
            latched   = FIELDS_RESET;
            tick_cnt  = TICK_W'(SYMBOL_TICKS);
            sym_idx   = FIRST_INDEX;
            pair_cnt  = '0;
            frame_cnt = '0;
            active    = 1'b1;
            cur_sym   = 1'b1;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [NIB_W-1:0] val);
            case (idx)
                CFG_ROBOT_NUMBER: regs.number = val;
                CFG_ROBOT_SPEED:  regs.speed  = val;
                CFG_ROBOT_STATUS: regs.status = val;
                default: ;
            endcase
        endfunction

        // Symbol at a given index of the frame, from the latched fields.
        function logic frame_symbol(logic [IDX_W-1:0] idx);
            logic [NIB_W-1:0] chk;
            logic [15:0]      word;
            int               k;
            chk  = NIB_W'(-(int'(latched.number) + int'(latched.speed) + int'(latched.status)));
            word = {latched.number, latched.speed, latched.status, chk};
            if (idx >= FIRST_INDEX) return 1'b1;
            if (idx == FIRST_INDEX - 1) return 1'b0;
            if (idx == 1) return 1'b1;
            if (idx == 0) return 1'b0;
            k = int'(idx) - 2;
            case (k % 3)
                0: return 1'b0;
                2: return 1'b1;
                default: return word[k / 3];
            endcase
        endfunction

        function void note_tick(logic enable);
            t_result r;
            r.carrier_on     = cur_sym & active;
            r.burst_active   = active;
            r.frame_reloaded = 1'b0;
            if (enable) begin
                ticks++;
                if (tick_cnt > 0) tick_cnt--;
                if (tick_cnt == 0) begin
                    if (sym_idx > 0) begin
                        sym_idx--;
                    end else begin
                        // trailing pair restarts
                        sym_idx = IDX_W'(1);
                        pair_cnt++;
                    end
                    if (pair_cnt == PAIR_STARTS) begin
                        sym_idx  = FIRST_INDEX;
                        pair_cnt = '0;
                        if (active) begin
                            frame_cnt++;
                        end else if (frame_cnt > 0) begin
                            frame_cnt--;
                        end
                        if (frame_cnt == FRAME_W'(FRAME_REPEATS)) active = 1'b0;
                        if (frame_cnt == 0) begin
                            latched          = regs;
                            active           = 1'b1;
                            r.frame_reloaded = 1'b1;
                            relatches++;
                        end
                    end
                    cur_sym  = frame_symbol(sym_idx);
                    tick_cnt = TICK_W'(SYMBOL_TICKS);
                end
            end else begin
                held++;
            end
            expected_outputs.push_back(r);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch on %s: got %0d, expected %0d (result %0d)",
                     what, got, want, checked);
            errors++;
        endtask

        task check_output(t_result got);
            t_result want;
            if (expected_outputs.size() == 0) begin
                report("result with nothing pending", 1, 0);
            end else begin
                want = expected_outputs.pop_front();
                if (got.carrier_on !== want.carrier_on)
                    report("carrier_on", got.carrier_on, want.carrier_on);
                if (got.burst_active !== want.burst_active)
                    report("burst_active", got.burst_active, want.burst_active);
                if (got.frame_reloaded !== want.frame_reloaded)
                    report("frame_reloaded", got.frame_reloaded, want.frame_reloaded);
            end
            checked++;
        endtask
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic                 i_tick_enable = 1'b0;
    logic                 i_out_stall   = 1'b0;
    logic                 i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr    = '0;
    logic [NIB_W-1:0]     i_cfg_wr_data = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_carrier_on;
    logic                 o_burst_active;
    logic                 o_frame_reloaded;

    carrier_scoreboard sb;
    int                tx_idle_pct  = 0;
    int                rx_stall_pct = 0;
    int                hold_left    = 0;
    int                cycle_count  = 0;

    ir_beacon_frame_transmitter uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_tick_enable    (i_tick_enable),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_carrier_on     (o_carrier_on),
        .o_burst_active   (o_burst_active),
        .o_frame_reloaded (o_frame_reloaded),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wr_data    (i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: abandon the run if it never drains.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.expected_outputs.size());
            $display("FAIL ir_beacon_frame_transmitter");
            $finish;
        end
    end

    // Result side: check whatever was accepted at this edge (values read here
    // are the pre-edge ones), then pick the stall for the next cycle. A long
    // hold-off is counted down here so the sender keeps pushing meanwhile.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall)
                sb.check_output({o_carrier_on, o_burst_active, o_frame_reloaded});
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left = hold_left - 1;
            end else begin
                i_out_stall <= ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    // Offer one tick transaction, with random idle cycles ahead of it, and
    // hold it steady until the block takes it.
    task send_tick(input logic enable);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_tick_enable <= enable;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_tick(enable);
    endtask

    // Drop valid and wait for every outstanding result, plus a short margin.
    task wait_idle();
        i_in_valid <= 1'b0;
        while (sb.expected_outputs.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [NIB_W-1:0] data);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= idx;
        i_cfg_wr_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // Load all three fields and poke the unused index; the block is idle here.
    task write_settings(input logic [NIB_W-1:0] number, speed, status, spare);
        cfg_write(CFG_ROBOT_NUMBER, number);
        cfg_write(CFG_ROBOT_SPEED, speed);
        cfg_write(CFG_ROBOT_STATUS, status);
        cfg_write(CFG_SPARE, spare);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Mostly advancing ticks, some held ticks and the odd run of held ticks.
    // Run until enough advancing ticks have gone by.
    task run_phase(input int tx_pct, input int rx_pct);
        int start_ticks;
        int pick;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        start_ticks  = sb.ticks;
        while (sb.ticks - start_ticks < PHASE_TICKS) begin
            pick = $urandom_range(99);
            if (pick < 2) begin
                repeat ($urandom_range(20, 1)) send_tick(1'b0);
            end else if (pick < 10) begin
                send_tick(1'b0);
            end else begin
                send_tick(1'b1);
            end
        end
        wait_idle();
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Top fields after reset; the first burst must still carry the
        // reset fields, since writes land only at the next relatch.
        write_settings(4'hF, 4'hF, 4'hF, 4'h5);

        // Directed: held ticks, a full symbol, then held and advancing mixed.
        repeat (3) send_tick(1'b0);
        repeat (15) send_tick(1'b1);
        send_tick(1'b0);
        repeat (2) send_tick(1'b1);
        send_tick(1'b0);
        repeat (2) send_tick(1'b1);
        wait_idle();

        // Sender idles lightly, receiver heavily, with one long hold-off
        // at the start so the skid entry fills and the input stalls.
        hold_left = HOLD_OFF_LONG;
        run_phase(20, 59);

        write_settings(4'h0, 4'h0, 4'h0, 4'hA);
        run_phase(59, 20);

        write_settings(NIB_W'($urandom_range(15)), NIB_W'($urandom_range(15)),
                       NIB_W'($urandom_range(15)), NIB_W'($urandom_range(15)));
        run_phase(0, 0);

        $display("covered %0d tick transactions (%0d held) over %0d field relatches",
                 sb.ticks + sb.held, sb.held, sb.relatches);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("PASS ir_beacon_frame_transmitter");
        end else begin
            $display("FAIL ir_beacon_frame_transmitter");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== ir_beacon_frame_transmitter.f =====
+incdir+src
src/ibft_pkg.sv
src/ibft_cfg.sv
src/ibft_seq.sv
src/ibft_out_buf.sv
src/ir_beacon_frame_transmitter.sv
tb/sv/tb_ir_beacon_frame_transmitter.sv
